// ----- src/fqkr_pkg.sv -----
// shared types and constants for the keyed-remove task queue
// no dependencies; used by the interfaces, the cell and the top level
`default_nettype none

package fqkr_pkg;

   localparam int DEPTH    = 16;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int HANDLE_W = 16;
   localparam int LIMIT_W  = 16;
   localparam int COUNT_W  = 5;

   typedef enum logic [1:0] {
      OP_PUT    = 2'd0,
      OP_TAKE   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_EXEC
   } state_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic                compare_en;
      logic                commit_en;
      logic                take;
      logic                remove;
      logic                load;
      logic [HANDLE_W-1:0] key;
      logic [LIMIT_W-1:0]  load_limit;
   } cell_ctrl_type;

   // reported count, wrapped to the result field width
   function automatic logic [COUNT_W-1:0] count_out(input logic [CNT_W-1:0] cnt);
      logic [CNT_W+COUNT_W-1:0] wide;
      wide = {{COUNT_W{1'b0}}, cnt};
      return wide[COUNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- src/fqkr_if.sv -----
// valid/ready channel interfaces for request and response words
// depends on fqkr_pkg
`default_nettype none

interface fqkr_req_if;
   import fqkr_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          op;
   logic [HANDLE_W-1:0] item_handle;
   logic [LIMIT_W-1:0]  time_limit;

   modport source (output valid, op, item_handle, time_limit, input ready);
   modport sink   (input valid, op, item_handle, time_limit, output ready);
endinterface

interface fqkr_rsp_if;
   import fqkr_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic [HANDLE_W-1:0] taken_handle;
   logic [LIMIT_W-1:0]  taken_limit;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, status, taken_handle, taken_limit, entry_count,
                   input ready);
   modport sink   (input valid, status, taken_handle, taken_limit, entry_count,
                   output ready);
endinterface

`default_nettype wire

// ----- src/fqkr_cell.sv -----
// one queue slot: holds a handle and limit, matches the key, shifts toward the head
// depends on fqkr_pkg
`default_nettype none

module fqkr_cell
   import fqkr_pkg::*;
(
   input  wire logic                clock,
   input  wire cell_ctrl_type       ctrl,
   input  wire logic                in_range,
   input  wire logic                load_en,
   input  wire logic [HANDLE_W-1:0] next_handle,
   input  wire logic [LIMIT_W-1:0]  next_limit,
   input  wire logic                found_in,
   output logic                     found_out,
   output logic [HANDLE_W-1:0]      handle,
   output logic [LIMIT_W-1:0]       limit
);

   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic                match_ff, match_in;
   logic                shift;

   // match flag and first-match propagation toward the tail
   always_comb begin
      match_in  = ctrl.compare_en ? (in_range && (handle_ff == ctrl.key)) : match_ff;
      found_out = found_in | match_ff;
      shift     = ctrl.take | (ctrl.remove & (found_in | match_ff));
   end

   // slot update: shift from the neighbor or load at the tail
   always_comb begin
      handle_in = handle_ff;
      limit_in  = limit_ff;
      if (ctrl.commit_en) begin
         if (shift) begin
            handle_in = next_handle;
            limit_in  = next_limit;
         end else if (ctrl.load && load_en) begin
            handle_in = ctrl.key;
            limit_in  = ctrl.load_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      limit_ff  <= limit_in;
      match_ff  <= match_in;
   end

   assign handle = handle_ff;
   assign limit  = limit_ff;

endmodule

`default_nettype wire

// ----- src/fifo_queue_with_keyed_remove_top.sv -----
// Bounded task queue with put, take, remove-by-handle and clear. Each request
// word first has a match step, where every slot compares its handle with the
// key, then a shift step, where the slot chain shifts toward the head, loads
// the tail and the response word is registered. A new request is accepted in
// the shift step of the previous one, so a new word can start before the last
// one is through; a stalled response holds the queue in its shift step.
// The row of slot cells keeps compare and shift as separate steps.
// depends on fqkr_pkg, fqkr_if and fqkr_cell
`default_nettype none

module fifo_queue_with_keyed_remove_top
   import fqkr_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   fqkr_req_if.sink    req,
   fqkr_rsp_if.source  rsp
);

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [HANDLE_W-1:0] key_ff, key_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [LIMIT_W-1:0]  rsp_limit_ff, rsp_limit_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                commit;
   logic                accept;
   logic                full;
   logic                empty;
   cell_ctrl_type       ctrl;

   logic [DEPTH:0]      found_chain;
   logic [HANDLE_W-1:0] cell_handle [DEPTH+1];
   logic [LIMIT_W-1:0]  cell_limit  [DEPTH+1];

   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign commit = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp.ready);
   assign accept = req.valid && req.ready;

   // request ready in idle or while the current word finishes
   assign req.ready = (state_ff == ST_IDLE) || commit;

   // cell control broadcast
   always_comb begin
      ctrl.compare_en = (state_ff == ST_MATCH);
      ctrl.commit_en  = commit;
      ctrl.take       = (op_ff == OP_TAKE) && !empty;
      ctrl.remove     = (op_ff == OP_REMOVE);
      ctrl.load       = (op_ff == OP_PUT) && !full;
      ctrl.key        = key_ff;
      ctrl.load_limit = limit_ff;
   end

   // slot chain, head at index zero
   assign found_chain[0]    = 1'b0;
   assign cell_handle[DEPTH] = '0;
   assign cell_limit[DEPTH]  = '0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      fqkr_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .in_range    (CNT_W'(g) < count_ff),
         .load_en     (CNT_W'(g) == count_ff),
         .next_handle (cell_handle[g+1]),
         .next_limit  (cell_limit[g+1]),
         .found_in    (found_chain[g]),
         .found_out   (found_chain[g+1]),
         .handle      (cell_handle[g]),
         .limit       (cell_limit[g])
      );
   end

   // sequencer: next state, request capture, count and response
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      limit_in      = limit_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_limit_in  = rsp_limit_ff;
      rsp_count_in  = rsp_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (commit) begin
               state_in      = accept ? ST_MATCH : ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_handle_in = '0;
               rsp_limit_in  = '0;
               unique case (op_ff)
                  OP_PUT: begin
                     if (full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_TAKE: begin
                     if (empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_handle_in = cell_handle[0];
                        rsp_limit_in  = cell_limit[0];
                        count_in      = count_ff - 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (found_chain[DEPTH]) begin
                        count_in = count_ff - 1'b1;
                     end else begin
                        rsp_status_in = STAT_NOT_FOUND;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     rsp_status_in = STAT_OK;
                  end
               endcase
               rsp_count_in = count_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (accept) begin
         op_in    = op_type'(req.op);
         key_in   = req.item_handle;
         limit_in = req.time_limit;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      limit_ff      <= limit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_limit_ff  <= rsp_limit_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.taken_handle = rsp_handle_ff;
   assign rsp.taken_limit  = rsp_limit_ff;
   assign rsp.entry_count  = count_out(rsp_count_ff);

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// testbench for the keyed-remove task queue: directed and random request words,
// each response word checked against a queue model kept here
// depends on fqkr_pkg, fqkr_if and fifo_queue_with_keyed_remove_top

module testbench;
   import fqkr_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 12;
   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_WORDS  = 1200;
   localparam int STEADY_WORDS  = 150;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [HANDLE_W-1:0] DUP_HANDLE    = 16'hA5A5;
   localparam logic [HANDLE_W-1:0] ABSENT_HANDLE = 16'h1234;

   typedef struct packed {
      status_type          status;
      logic [HANDLE_W-1:0] taken_handle;
      logic [LIMIT_W-1:0]  taken_limit;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fqkr_req_if req_ch ();
   fqkr_rsp_if rsp_ch ();

   fifo_queue_with_keyed_remove_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // queue image, head at position 0
   logic [HANDLE_W-1:0] model_handles [DEPTH];
   logic [LIMIT_W-1:0]  model_limits  [DEPTH];
   int                  model_count = 0;

   rsp_word_type pending_rsp [$];
   int           failures    = 0;
   int           quiet_count = 0;
   int           stall_left  = 0;
   bit           idle_on     = 1'b0;

   // clock
   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // apply one request word to the queue image and return its response word
   function automatic rsp_word_type queue_step(op_type op, logic [HANDLE_W-1:0] handle,
                                               logic [LIMIT_W-1:0] limit);
      rsp_word_type word;
      int           pos;
      int           i;
      word        = '0;
      word.status = STAT_OK;
      pos         = -1;
      case (op)
         OP_PUT: begin
            if (model_count >= DEPTH) begin
               word.status = STAT_FULL;
            end else begin
               model_handles[model_count] = handle;
               model_limits[model_count]  = limit;
               model_count++;
            end
         end
         OP_TAKE: begin
            if (model_count == 0) begin
               word.status = STAT_EMPTY;
            end else begin
               word.taken_handle = model_handles[0];
               word.taken_limit  = model_limits[0];
               pos = 0;
            end
         end
         OP_REMOVE: begin
            word.status = STAT_NOT_FOUND;
            for (i = 0; i < model_count && pos < 0; i++) begin
               if (model_handles[i] == handle) begin
                  pos         = i;
                  word.status = STAT_OK;
               end
            end
         end
         default: begin
            model_count = 0;
         end
      endcase
      // close the gap left by a take or a remove
      if (pos >= 0) begin
         for (i = pos; i < model_count - 1; i++) begin
            model_handles[i] = model_handles[i + 1];
            model_limits[i]  = model_limits[i + 1];
         end
         model_count--;
      end
      word.entry_count = model_count[COUNT_W-1:0];
      return word;
   endfunction

   // drive one request word, with an optional gap before it
   task automatic send_word(op_type op, logic [HANDLE_W-1:0] handle,
                            logic [LIMIT_W-1:0] limit);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       = 1'b1;
      req_ch.op          = op;
      req_ch.item_handle = handle;
      req_ch.time_limit  = limit;
      do @(posedge clock); while (!req_ch.ready);
      pending_rsp.push_back(queue_step(op, handle, limit));
   endtask

   // stop sending and wait for every outstanding response word
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // response side: random stall bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready = 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ch.ready = 1'b0;
         stall_left   = $urandom_range(1, 18) - 1;
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   // response check and watchdog
   always @(posedge clock) begin : check_rsp
      rsp_word_type want;
      if (reset) begin
         quiet_count = 0;
      end else begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_count = 0;
         else
            quiet_count++;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
               $error("response word with no request outstanding");
               failures++;
            end else begin
               want = pending_rsp.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_ch.status));
               check_field("taken_handle", 16'(want.taken_handle),
                           16'(rsp_ch.taken_handle));
               check_field("taken_limit", 16'(want.taken_limit),
                           16'(rsp_ch.taken_limit));
               check_field("entry_count", 16'(want.entry_count),
                           16'(rsp_ch.entry_count));
            end
         end
         if (quiet_count >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // take, remove and clear on an empty queue
   task automatic test_empty_queue();
      send_word(OP_TAKE, 16'h0000, 16'h0000);
      send_word(OP_REMOVE, 16'h0000, 16'hFFFF);
      send_word(OP_CLEAR, 16'hFFFF, 16'hFFFF);
   endtask

   // fill every slot with extreme and repeated handles, then put once more
   task automatic test_fill_and_overflow();
      logic [HANDLE_W-1:0] handle;
      logic [LIMIT_W-1:0]  limit;
      for (int i = 0; i < DEPTH; i++) begin
         if (i == 0)
            handle = 16'h0000;
         else if (i == 1)
            handle = 16'hFFFF;
         else if (i % 3 == 0 && i < DEPTH - 1)
            handle = DUP_HANDLE;
         else
            handle = HANDLE_W'(16'h0100 + i);
         limit = (i == 0) ? 16'hFFFF : ~handle;
         send_word(OP_PUT, handle, limit);
      end
      send_word(OP_PUT, 16'h7777, 16'h8888);
   endtask

   // absent handle, repeated handle, tail entry and a zero handle at the head
   task automatic test_remove_by_handle();
      send_word(OP_REMOVE, ABSENT_HANDLE, 16'h0000);
      send_word(OP_REMOVE, DUP_HANDLE, 16'h0000);
      send_word(OP_REMOVE, HANDLE_W'(16'h0100 + DEPTH - 1), 16'h0000);
      send_word(OP_REMOVE, 16'h0000, 16'h0000);
   endtask

   task automatic test_take_and_clear();
      send_word(OP_TAKE, 16'h0000, 16'h0000);
      send_word(OP_CLEAR, 16'h0000, 16'h0000);
      send_word(OP_TAKE, 16'hFFFF, 16'hFFFF);
   endtask

   // random traffic in fill, drain and mixed phases with a small handle pool
   task automatic test_random_traffic(int words, bit with_idle);
      int                  n;
      int                  r;
      int                  put_pct;
      int                  take_pct;
      op_type              op;
      logic [HANDLE_W-1:0] handle;
      logic [LIMIT_W-1:0]  limit;
      put_pct  = 35;
      take_pct = 30;
      idle_on  = with_idle;
      for (n = 0; n < words; n++) begin
         if (n % 60 == 0) begin
            case ($urandom_range(0, 2))
               0:       begin put_pct = 60; take_pct = 15; end
               1:       begin put_pct = 20; take_pct = 45; end
               default: begin put_pct = 35; take_pct = 30; end
            endcase
         end
         if (with_idle && n % 100 == 0)
            idle_on = ($urandom_range(0, 3) != 0);
         // hold off until the queue has answered everything sent so far
         if (n % 300 == 299)
            wait_drained();
         r = $urandom_range(0, 99);
         if (r < put_pct)
            op = OP_PUT;
         else if (r < put_pct + take_pct)
            op = OP_TAKE;
         else if (r < 98)
            op = OP_REMOVE;
         else
            op = OP_CLEAR;
         handle = ($urandom_range(0, 3) == 0) ? HANDLE_W'($urandom_range(0, 16'hFFFF))
                                             : HANDLE_W'($urandom_range(0, 11));
         limit  = LIMIT_W'($urandom_range(0, 16'hFFFF));
         if (op == OP_REMOVE && model_count > 0 && $urandom_range(0, 2) != 0)
            handle = model_handles[$urandom_range(0, model_count - 1)];
         send_word(op, handle, limit);
      end
   endtask

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.op          = OP_PUT;
      req_ch.item_handle = '0;
      req_ch.time_limit  = '0;
      rsp_ch.ready       = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      idle_on = 1'b1;
      test_empty_queue();
      test_fill_and_overflow();
      test_remove_by_handle();
      test_take_and_clear();
      wait_drained();
      test_random_traffic(RANDOM_WORDS - STEADY_WORDS, 1'b1);
      test_random_traffic(STEADY_WORDS, 1'b0);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
